[rtl/i2c_master_transfer_sequencer_unit_assert.svh]
// Assertion macros for the I2C master transfer sequencer.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define I2CMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define I2CMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define I2CMS_ASSERT(lbl, prop, msg)
`define I2CMS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[rtl/i2cms_pkg.sv]
package i2cms_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACK_KEEP   = 2'd0,
    ACK_ASSERT = 2'd1,
    ACK_NACK   = 2'd2
  } ack_e;

  typedef enum logic [1:0] {
    XS_BUSY = 2'd0,
    XS_OK   = 2'd1,
    XS_ERR  = 2'd2
  } xfer_status_e;

  // Bus engine status codes.
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
  localparam logic [7:0] ST_DATW_ACK    = 8'h28;
  localparam logic [7:0] ST_DATW_NACK   = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
  localparam logic [7:0] ST_DATR_ACK    = 8'h50;
  localparam logic [7:0] ST_DATR_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] target_address;
    logic [7:0] transfer_length;
    logic [7:0] buffer_index;
    logic [7:0] write_byte;
    logic [7:0] bus_status;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic       start_request;
    logic       start_clear;
    logic       stop_request;
    logic [1:0] ack_control;
    logic [7:0] data_out;
    logic       data_out_valid;
    logic [7:0] read_byte;
    logic [7:0] read_index;
    logic       read_valid;
    logic [1:0] transfer_status;
    logic       done_res;
  } out_item_t;

endpackage

[rtl/i2cms_in_if.sv]
interface i2cms_in_if import i2cms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/i2cms_out_if.sv]
interface i2cms_out_if import i2cms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/i2c_master_transfer_sequencer_unit.sv]
// I2C master transfer sequencer: turns start, buffer-load and bus status items into the
// action items for a byte-level I2C engine. Load items fill the write buffer and give no
// result; every start item and status event gives exactly one result item. One item can be
// accepted every clock cycle. A result is held first in the stage behind the input, while the
// write buffer memory is read (it is read for every item that gives a result), and then in
// the output register. While a result waits on a stalled output, the stage behind it holds
// and the input is not ready. The buffer reads as zero after reset through one valid bit
// per entry, so no clearing pass is needed.
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module i2c_master_transfer_sequencer_unit import i2cms_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cms_in_if.sink    in_i,
  i2cms_out_if.source out_o
);

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0]  DEPTH9 = 9'(BUFFER_DEPTH);

  // Write buffer and its per-entry valid bits.
  logic [7:0] mem [BUFFER_DEPTH];
  logic       vld_q [BUFFER_DEPTH];

  // Scalar transfer state.
  logic [7:0] addr_byte_q, addr_byte_d;
  logic [7:0] len_q, len_d;
  logic [7:0] idx_q, idx_d;
  logic [1:0] status_q, status_d;

  // Stage after acceptance, waiting for the buffer read data.
  logic       s1_vld_q;
  out_item_t  s1_q, s1_d;
  logic       s1_mem_q, s1_mem_d;
  logic       s1_rng_q;
  logic [7:0] rd_data_q;
  logic       rd_vld_q;

  // Output register.
  logic       out_vld_q;
  out_item_t  out_q, out_d;

  logic       in_acc, is_load, has_result, s1_adv;
  logic [7:0] rd_idx;
  logic       rd_rng, wr_rng;
  logic [7:0] idx_inc;
  logic [8:0] ack_sum;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = (mode_e'(in_i.payload.mode) == MODE_LOAD);
  assign has_result = in_acc && !is_load;

  assign rd_rng = ({1'b0, rd_idx} < DEPTH9);
  assign wr_rng = ({1'b0, in_i.payload.buffer_index} < DEPTH9);
  assign idx_inc = idx_q + 8'd1;

  always_comb begin
    addr_byte_d = addr_byte_q;
    len_d       = len_q;
    idx_d       = idx_q;
    status_d    = status_q;
    s1_d        = '0;
    s1_mem_d    = 1'b0;
    rd_idx      = idx_q;
    ack_sum     = '0;
    unique case (mode_e'(in_i.payload.mode))
      MODE_WRITE, MODE_READ: begin
        addr_byte_d        = {in_i.payload.target_address, in_i.payload.mode[0]};
        len_d              = in_i.payload.transfer_length;
        idx_d              = '0;
        status_d           = XS_BUSY;
        s1_d.start_request = 1'b1;
        s1_d.ack_control   = ACK_NACK;
      end
      MODE_LOAD: begin
      end
      MODE_STATUS: begin
        s1_d.start_clear = 1'b1;
        case (in_i.payload.bus_status) inside
          ST_START, ST_RSTART: begin
            s1_d.data_out       = addr_byte_q;
            s1_d.data_out_valid = 1'b1;
            idx_d               = '0;
          end
          ST_SLAW_ACK: begin
            s1_d.data_out_valid = 1'b1;
            s1_mem_d            = 1'b1;
          end
          ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: begin
            s1_d.stop_request = 1'b1;
            s1_d.done_res     = 1'b1;
            status_d          = XS_ERR;
          end
          ST_DATW_ACK: begin
            idx_d  = idx_inc;
            rd_idx = idx_inc;
            if (idx_inc >= len_q) begin
              s1_d.stop_request = 1'b1;
              s1_d.done_res     = 1'b1;
              status_d          = XS_OK;
            end else begin
              s1_d.data_out_valid = 1'b1;
              s1_mem_d            = 1'b1;
            end
          end
          ST_ARB_LOST: begin
            s1_d.start_clear   = 1'b0;
            s1_d.start_request = 1'b1;
          end
          ST_SLAR_ACK: begin
            ack_sum          = {1'b0, idx_q} + 9'd1;
            s1_d.ack_control = (ack_sum >= {1'b0, len_q}) ? ACK_NACK : ACK_ASSERT;
          end
          ST_DATR_ACK: begin
            if (idx_q < len_q) begin
              s1_d.read_byte  = in_i.payload.received_byte;
              s1_d.read_index = idx_q;
              s1_d.read_valid = 1'b1;
              idx_d           = idx_inc;
            end
            // The acknowledge decision uses the index after this byte.
            ack_sum          = {1'b0, idx_d} + 9'd1;
            s1_d.ack_control = (ack_sum >= {1'b0, len_q}) ? ACK_NACK : ACK_ASSERT;
          end
          ST_DATR_NACK: begin
            if (idx_q < len_q) begin
              s1_d.read_byte  = in_i.payload.received_byte;
              s1_d.read_index = idx_q;
              s1_d.read_valid = 1'b1;
              idx_d           = idx_inc;
            end
            s1_d.stop_request = 1'b1;
            s1_d.done_res     = 1'b1;
            status_d          = XS_OK;
          end
          default: begin
            // Unknown code: end in error without a stop condition.
            s1_d.ack_control = ACK_ASSERT;
            s1_d.done_res    = 1'b1;
            status_d         = XS_ERR;
          end
        endcase
      end
      default: begin
      end
    endcase
    s1_d.transfer_status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_byte_q <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      status_q    <= XS_BUSY;
    end else if (has_result) begin
      addr_byte_q <= addr_byte_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
    end
  end

  // Buffer memory: one write port for load items, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_load && wr_rng) begin
      mem[in_i.payload.buffer_index[AW-1:0]] <= in_i.payload.write_byte;
    end
    if (has_result) begin
      rd_data_q <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (in_acc && is_load && wr_rng) begin
        vld_q[in_i.payload.buffer_index[AW-1:0]] <= 1'b1;
      end
      if (has_result) begin
        rd_vld_q <= vld_q[rd_idx[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (has_result) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_result) begin
      s1_q     <= s1_d;
      s1_mem_q <= s1_mem_d;
      s1_rng_q <= rd_rng;
    end
  end

  // Merge the buffer byte into the result; entries never loaded read as zero.
  always_comb begin
    out_d = s1_q;
    if (s1_mem_q) begin
      out_d.data_out = (s1_rng_q && rd_vld_q) ? rd_data_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  `I2CMS_ASSERT_IMPL(a_stall_blocks_input, s1_vld_q && out_vld_q && !out_o.ready, !in_i.ready, "input accepted while both stages are full and stalled")
  `I2CMS_ASSERT_IMPL(a_done_not_busy, out_vld_q && out_q.done_res, out_q.transfer_status != XS_BUSY, "completed transfer reported as busy")
  `I2CMS_ASSERT_IMPL(a_done_without_stop, out_vld_q && out_q.done_res && !out_q.stop_request, out_q.transfer_status == XS_ERR, "transfer ended without stop but not in error")
  `I2CMS_ASSERT(a_read_or_send, !(out_vld_q && out_q.read_valid && out_q.data_out_valid), "received byte and transmit byte in one result")

endmodule

[bench/tb_i2c_master_transfer_sequencer_unit.sv]
module tb_i2c_master_transfer_sequencer_unit;
  import i2cms_pkg::*;

  localparam longint CYCLE_LIMIT = 200000;
  localparam int     RANDOM_ITEMS = 400;

  typedef struct {
    bit       pause;
    in_item_t item;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_transfer_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predicted state of the sequencer.
  logic [7:0]   lat_addr = '0;
  logic [7:0]   lat_len = '0;
  logic [7:0]   xfer_idx = '0;
  xfer_status_e xfer_stat = XS_BUSY;
  logic [7:0]   tx_buf [256];

  pending_t  pend_q [$];
  out_item_t bus_actions_q [$];

  logic [7:0] bus_codes [11] = '{ST_START, ST_RSTART, ST_SLAW_ACK, ST_SLAW_NACK, ST_DATW_ACK,
                                 ST_DATW_NACK, ST_ARB_LOST, ST_SLAR_ACK, ST_SLAR_NACK,
                                 ST_DATR_ACK, ST_DATR_NACK};

  int     n_errors = 0;
  int     n_planned = 0;
  int     n_accepted = 0;
  int     n_checked = 0;
  int     n_ok = 0;
  int     n_err = 0;
  int     n_pauses = 0;
  longint cycle_cnt = 0;
  logic   in_taken = 1'b0;
  int     gap_left = 0;
  int     burst_left = 0;
  logic [15:0] rdy_mask = '1;
  logic [3:0]  rdy_phase = '0;
  out_item_t   got_act;
  out_item_t   want_act;
  out_item_t   new_act;

  task automatic report_mismatch(string what);
    n_errors++;
    if (n_errors <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h", n_checked, name, got,
                                want));
  endtask

  function automatic logic [1:0] nack_or_ack();
    return ({1'b0, xfer_idx} + 9'd1 >= {1'b0, lat_len}) ? ACK_NACK : ACK_ASSERT;
  endfunction

  function automatic void end_transfer(inout out_item_t r, input xfer_status_e code,
                                       input bit stop);
    xfer_stat = code;
    r.done_res = 1'b1;
    if (stop) r.stop_request = 1'b1;
  endfunction

  function automatic void hand_back(inout out_item_t r, input logic [7:0] rx);
    if (xfer_idx < lat_len) begin
      r.read_byte = rx;
      r.read_index = xfer_idx;
      r.read_valid = 1'b1;
      xfer_idx = xfer_idx + 8'd1;
    end
  endfunction

  // Returns 1 where the item gives a result; load items only update the buffer.
  function automatic bit predict_bus_actions(input in_item_t it, output out_item_t r);
    r = '0;
    if (it.mode == MODE_LOAD) begin
      tx_buf[it.buffer_index] = it.write_byte;
      return 1'b0;
    end
    if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
      lat_addr = {it.target_address, it.mode[0]};
      lat_len = it.transfer_length;
      xfer_idx = '0;
      xfer_stat = XS_BUSY;
      r.start_request = 1'b1;
      r.ack_control = ACK_NACK;
    end else begin
      case (it.bus_status)
        ST_START, ST_RSTART: begin
          r.data_out = lat_addr;
          r.data_out_valid = 1'b1;
          r.start_clear = 1'b1;
          xfer_idx = '0;
        end
        ST_SLAW_ACK: begin
          r.data_out = tx_buf[xfer_idx];
          r.data_out_valid = 1'b1;
          r.start_clear = 1'b1;
        end
        ST_SLAW_NACK, ST_DATW_NACK, ST_SLAR_NACK: begin
          r.start_clear = 1'b1;
          end_transfer(r, XS_ERR, 1'b1);
        end
        ST_DATW_ACK: begin
          xfer_idx = xfer_idx + 8'd1;
          r.start_clear = 1'b1;
          if (xfer_idx >= lat_len) begin
            end_transfer(r, XS_OK, 1'b1);
          end else begin
            r.data_out = tx_buf[xfer_idx];
            r.data_out_valid = 1'b1;
          end
        end
        ST_ARB_LOST: r.start_request = 1'b1;
        ST_SLAR_ACK: begin
          r.start_clear = 1'b1;
          r.ack_control = nack_or_ack();
        end
        ST_DATR_ACK: begin
          hand_back(r, it.received_byte);
          r.start_clear = 1'b1;
          r.ack_control = nack_or_ack();
        end
        ST_DATR_NACK: begin
          hand_back(r, it.received_byte);
          r.start_clear = 1'b1;
          end_transfer(r, XS_OK, 1'b1);
        end
        default: begin
          r.start_clear = 1'b1;
          r.ack_control = ACK_ASSERT;
          end_transfer(r, XS_ERR, 1'b0);
        end
      endcase
    end
    r.transfer_status = xfer_stat;
    return 1'b1;
  endfunction

  // Every field gets random content, so that bits unused by a mode toggle as well.
  function automatic in_item_t any_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[48:0];
  endfunction

  task automatic add_item(in_item_t it);
    pend_q.push_back('{1'b0, it});
    n_planned++;
  endtask

  task automatic add_pause();
    pend_q.push_back('{1'b1, '0});
  endtask

  task automatic add_start(mode_e m, logic [6:0] addr, logic [7:0] len);
    in_item_t it;
    it = any_item();
    it.mode = m;
    it.target_address = addr;
    it.transfer_length = len;
    add_item(it);
  endtask

  task automatic add_load(logic [7:0] idx, logic [7:0] b);
    in_item_t it;
    it = any_item();
    it.mode = MODE_LOAD;
    it.buffer_index = idx;
    it.write_byte = b;
    add_item(it);
  endtask

  task automatic add_status(logic [7:0] code, logic [7:0] rx);
    in_item_t it;
    it = any_item();
    it.mode = MODE_STATUS;
    it.bus_status = code;
    it.received_byte = rx;
    add_item(it);
  endtask

  function automatic logic [7:0] pick_length();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) : 8'($urandom);
  endfunction

  task automatic add_addressing(mode_e m, logic [7:0] len);
    add_start(m, 7'($urandom), len);
    add_status(($urandom_range(0, 1) == 0) ? ST_START : ST_RSTART, 8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      add_status(ST_ARB_LOST, 8'($urandom));
      add_status(ST_START, 8'($urandom));
    end
  endtask

  // Long transfers are cut short by a NACK so that lengths span the whole field cheaply.
  task automatic write_transfer();
    logic [7:0] len;
    int n;
    len = pick_length();
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n && i < 9; i++) add_load(8'(i), 8'($urandom));
    if ($urandom_range(0, 3) == 0) add_load(8'($urandom), 8'($urandom));
    add_addressing(MODE_WRITE, len);
    if ($urandom_range(0, 7) == 0) begin
      add_status(ST_SLAW_NACK, 8'($urandom));
    end else begin
      add_status(ST_SLAW_ACK, 8'($urandom));
      if (n > 8) begin
        repeat ($urandom_range(0, 7)) add_status(ST_DATW_ACK, 8'($urandom));
        add_status(ST_DATW_NACK, 8'($urandom));
      end else begin
        repeat (n) add_status(ST_DATW_ACK, 8'($urandom));
      end
    end
  endtask

  task automatic read_transfer();
    logic [7:0] len;
    len = pick_length();
    add_addressing(MODE_READ, len);
    if ($urandom_range(0, 7) == 0) begin
      add_status(ST_SLAR_NACK, 8'($urandom));
    end else begin
      add_status(ST_SLAR_ACK, 8'($urandom));
      if (len > 8) repeat ($urandom_range(0, 7)) add_status(ST_DATR_ACK, 8'($urandom));
      else if (len > 0) repeat (len - 1) add_status(ST_DATR_ACK, 8'($urandom));
      add_status(ST_DATR_NACK, 8'($urandom));
    end
  endtask

  task automatic broken_transfer();
    add_start(($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_READ, 7'($urandom),
              pick_length());
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 3) == 0) add_status(8'($urandom), 8'($urandom));
      else add_status(bus_codes[$urandom_range(0, 10)], 8'($urandom));
    end
  endtask

  task automatic noise_items();
    in_item_t it;
    repeat ($urandom_range(1, 4)) begin
      it = any_item();
      if (it.mode == MODE_STATUS && $urandom_range(0, 1) == 0)
        it.bus_status = bus_codes[$urandom_range(0, 10)];
      add_item(it);
    end
  endtask

  // Sender: bursts of items with gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pend_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pend_q[0].pause) begin
        in_if.valid <= 1'b0;
        if (bus_actions_q.size() == 0) begin
          void'(pend_q.pop_front());
          n_pauses++;
        end
      end else begin
        in_if.payload <= pend_q[0].item;
        in_if.valid <= 1'b1;
        void'(pend_q.pop_front());
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: a fresh stall pattern each time the phase counter wraps, sometimes with no stalls at all.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rdy_phase == 4'd0) begin
        case ($urandom_range(0, 2))
          0: rdy_mask = '1;
          1: rdy_mask = 16'($urandom);
          default: rdy_mask = 16'($urandom & $urandom);
        endcase
      end
      out_if.ready <= rdy_mask[rdy_phase];
      rdy_phase = rdy_phase + 4'd1;
    end
  end

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        n_accepted++;
        if (predict_bus_actions(in_if.payload, new_act)) bus_actions_q.push_back(new_act);
      end
      if (out_if.valid && out_if.ready) begin
        got_act = out_if.payload;
        if (bus_actions_q.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want_act = bus_actions_q.pop_front();
          check_field("start_request", 8'(got_act.start_request), 8'(want_act.start_request));
          check_field("start_clear", 8'(got_act.start_clear), 8'(want_act.start_clear));
          check_field("stop_request", 8'(got_act.stop_request), 8'(want_act.stop_request));
          check_field("ack_control", 8'(got_act.ack_control), 8'(want_act.ack_control));
          check_field("data_out", got_act.data_out, want_act.data_out);
          check_field("data_out_valid", 8'(got_act.data_out_valid),
                      8'(want_act.data_out_valid));
          check_field("read_byte", got_act.read_byte, want_act.read_byte);
          check_field("read_index", got_act.read_index, want_act.read_index);
          check_field("read_valid", 8'(got_act.read_valid), 8'(want_act.read_valid));
          check_field("transfer_status", 8'(got_act.transfer_status),
                      8'(want_act.transfer_status));
          check_field("done_res", 8'(got_act.done_res), 8'(want_act.done_res));
          if (want_act.done_res) begin
            if (want_act.transfer_status == XS_OK) n_ok++;
            else n_err++;
          end
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               bus_actions_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    foreach (tx_buf[i]) tx_buf[i] = '0;

    // A status event straight after reset reads the cleared buffer.
    add_status(ST_SLAW_ACK, 8'hff);
    add_load(8'd0, 8'hff);
    add_load(8'd255, 8'ha5);
    // Zero length still sends the first buffer byte.
    add_start(MODE_WRITE, 7'h7f, 8'd0);
    add_status(ST_START, 8'h00);
    add_status(ST_SLAW_ACK, 8'h00);
    add_status(ST_DATW_ACK, 8'h00);
    // Read with a repeated start and a retry after lost arbitration.
    add_start(MODE_READ, 7'h00, 8'd255);
    add_status(ST_RSTART, 8'h00);
    add_status(ST_ARB_LOST, 8'h00);
    add_status(ST_RSTART, 8'h00);
    add_status(ST_SLAR_ACK, 8'h00);
    add_status(ST_DATR_ACK, 8'hff);
    add_status(ST_DATR_NACK, 8'h00);
    // Read codes during a write transfer still hand the byte back.
    add_start(MODE_WRITE, 7'h2a, 8'd1);
    add_status(ST_DATR_ACK, 8'h3c);
    add_status(ST_SLAR_NACK, 8'h00);
    // Error codes while idle, then codes the engine never reports.
    add_status(ST_SLAW_NACK, 8'h00);
    add_status(ST_DATW_NACK, 8'h00);
    add_status(8'h00, 8'h00);
    add_status(8'hff, 8'hff);
    add_status(8'h09, 8'h5a);
    // Zero-length read: no byte is handed back.
    add_start(MODE_READ, 7'h55, 8'd0);
    add_status(ST_SLAR_ACK, 8'h00);
    add_status(ST_DATR_NACK, 8'h77);
    add_pause();

    while (n_planned < RANDOM_ITEMS + 25) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: write_transfer();
        4, 5, 6: read_transfer();
        7, 8: broken_transfer();
        9, 10: noise_items();
        default: add_pause();
      endcase
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (bus_actions_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d items, checked %0d results in %0d cycles", n_accepted, n_checked,
             cycle_cnt);
    $display("transfers ended: %0d ok, %0d with error; %0d drain pauses; %0d mismatches",
             n_ok, n_err, n_pauses, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
